### rtl/core/swmo_pkg.sv
// ---------------------------------------------------------------------------
// swmo_pkg
// Shared types and codes for the stack with middle read and delete.
// ---------------------------------------------------------------------------
package swmo_pkg;

	// Capacity of the stack and the widths that follow from it
	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int DEPTH_W     = 7;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

	// Command codes
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_POP     = 2'd1;
	localparam logic [1:0] CMD_READ_MD = 2'd2;
	localparam logic [1:0] CMD_DEL_MD  = 2'd3;

	// Status codes
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]               cmd;
		logic signed [DATA_W-1:0] push_value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic [1:0]               status;
		logic [DEPTH_W-1:0]       depth_now;
	} rsp_item_t;

endpackage

### rtl/core/stack_with_middle_ops.sv
// ---------------------------------------------------------------------------
// stack_with_middle_ops
// Bounded stack of signed words with push, pop, read middle, delete middle.
// ---------------------------------------------------------------------------
// The entries live in one synchronous RAM (one write and one read per cycle,
// read data registered), bottom entry at address 0. The block works on one
// command at a time. Push, and any command that ends in the empty or full
// status, finishes straight from idle; pop and read middle first pass through
// a read state for the RAM read. Delete middle reads the middle entry, then
// the entries above the middle move down one place per cycle through the
// single RAM port pair. A finished result goes into an output register, so
// a new command is taken while the previous result still waits; if that
// register is still full when the next result is ready, the result is held
// and moves into the register at the same edge at which the waiting result
// is transferred, and the next command is taken from the following cycle.
// ---------------------------------------------------------------------------
module stack_with_middle_ops (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  swmo_pkg::cmd_item_t  cmd_item,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output swmo_pkg::rsp_item_t  rsp_item
);
	import swmo_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RD    = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic [1:0]        op_q, op_d;
	logic [DATA_W-1:0] word_q, word_d;
	logic [DATA_W-1:0] res_data_q, res_data_d;
	logic [1:0]        res_status_q, res_status_d;
	logic              rsp_valid_q, rsp_valid_d;
	rsp_item_t         rsp_item_q, rsp_item_d;

	// Entry RAM
	logic [DATA_W-1:0] entry_mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_wa, mem_ra;
	logic [DATA_W-1:0] mem_wd;

	logic              fin;
	logic [DATA_W-1:0] fin_data;
	logic [1:0]        fin_status;
	logic              out_ready;
	logic [CNT_W-1:0]  nxt_src;

	assign out_ready = !rsp_valid_q || !rsp_stall;
	assign nxt_src   = CNT_W'(ptr_q) + CNT_W'(1);
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	// Sequence commands through the RAM
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		ptr_d        = ptr_q;
		op_d         = op_q;
		word_d       = word_q;
		res_data_d   = res_data_q;
		res_status_d = res_status_q;
		mem_we       = 1'b0;
		mem_wa       = '0;
		mem_wd       = '0;
		mem_re       = 1'b0;
		mem_ra       = '0;
		fin          = 1'b0;
		fin_data     = '0;
		fin_status   = STATUS_OK;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					op_d = cmd_item.cmd;
					if (cmd_item.cmd == CMD_PUSH) begin
						fin = 1'b1;
						if (cnt_q >= FULL_CNT) begin
							fin_status = STATUS_FULL;
						end else begin
							mem_we = 1'b1;
							mem_wa = ADDR_W'(cnt_q);
							mem_wd = cmd_item.push_value;
							cnt_d  = cnt_q + CNT_W'(1);
						end
					end else if (cnt_q == '0) begin
						fin        = 1'b1;
						fin_status = STATUS_EMPTY;
					end else if (cmd_item.cmd == CMD_POP) begin
						mem_re  = 1'b1;
						mem_ra  = ADDR_W'(cnt_q - CNT_W'(1));
						cnt_d   = cnt_q - CNT_W'(1);
						state_d = S_RD;
					end else begin
						mem_re  = 1'b1;
						mem_ra  = ADDR_W'(cnt_q >> 1);
						ptr_d   = ADDR_W'(cnt_q >> 1);
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				if (op_q != CMD_DEL_MD) begin
					fin      = 1'b1;
					fin_data = rd_data_q;
				end else begin
					word_d = rd_data_q;
					if (nxt_src < cnt_q) begin
						mem_re  = 1'b1;
						mem_ra  = ADDR_W'(nxt_src);
						ptr_d   = ADDR_W'(nxt_src);
						state_d = S_SHIFT;
					end else begin
						cnt_d    = cnt_q - CNT_W'(1);
						fin      = 1'b1;
						fin_data = rd_data_q;
					end
				end
			end
			S_SHIFT: begin
				// move the arriving entry down one place
				mem_we = 1'b1;
				mem_wa = ptr_q - ADDR_W'(1);
				mem_wd = rd_data_q;
				if (nxt_src < cnt_q) begin
					mem_re = 1'b1;
					mem_ra = ADDR_W'(nxt_src);
					ptr_d  = ADDR_W'(nxt_src);
				end else begin
					cnt_d    = cnt_q - CNT_W'(1);
					fin      = 1'b1;
					fin_data = word_q;
				end
			end
			S_FIN: begin
				fin        = 1'b1;
				fin_data   = res_data_q;
				fin_status = res_status_q;
			end
		endcase

		// Hand the result to the output register or hold it
		if (fin) begin
			res_data_d   = fin_data;
			res_status_d = fin_status;
			if (out_ready) begin
				state_d = S_IDLE;
			end else begin
				state_d = S_FIN;
			end
		end
	end

	// Load or drain the output register
	always_comb begin
		rsp_valid_d = rsp_valid_q && rsp_stall;
		rsp_item_d  = rsp_item_q;
		if (fin && out_ready) begin
			rsp_valid_d          = 1'b1;
			rsp_item_d.data_out  = fin_data;
			rsp_item_d.status    = fin_status;
			rsp_item_d.depth_now = DEPTH_W'(cnt_d);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		ptr_q        <= ptr_d;
		op_q         <= op_d;
		word_q       <= word_d;
		res_data_q   <= res_data_d;
		res_status_q <= res_status_d;
		rsp_item_q   <= rsp_item_d;
	end

	// RAM write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= entry_mem[mem_ra];
		end
	end

endmodule

### rtl/core/swmo_checker.sv
// ---------------------------------------------------------------------------
// swmo_checker
// Port-level checks for the stack with middle read and delete.
// ---------------------------------------------------------------------------
module swmo_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input swmo_pkg::cmd_item_t cmd_item,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input swmo_pkg::rsp_item_t rsp_item
);
	import swmo_pkg::*;

	logic       cmd_xfer, rsp_xfer;
	logic [1:0] pend_q;

	assign cmd_xfer = cmd_valid && !cmd_stall;
	assign rsp_xfer = rsp_valid && !rsp_stall;

	// Count commands taken whose result has not been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(cmd_xfer) - 2'(rsp_xfer);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("result changed while stalled");

	a_no_extra_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("result without a pending command");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many commands in flight");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.status == STATUS_EMPTY |->
			rsp_item.depth_now == '0 && rsp_item.data_out == '0)
		else $error("empty status with nonzero depth or data");

endmodule

bind stack_with_middle_ops swmo_checker u_swmo_checker (.*);

### dv/stack_with_middle_ops_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stack_with_middle_ops_tb
// Self-checking bench for the stack with middle read and delete. A short
// table of directed commands runs first. Random bursts with changing push
// weight follow, so the stack fills to full and drains to empty many times.
// Each result is scored against its typed table row or a shadow stack. Both
// sides stall at random, with one long output hold-off and a calm stretch.
// ---------------------------------------------------------------------------
module stack_with_middle_ops_tb;
	import swmo_pkg::*;

	localparam int RAND_ITEMS   = 1300;
	localparam int WATCHDOG_LIM = 5000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 500;
	localparam int DRAIN_CYCLES = 50;

	typedef struct {
		cmd_item_t item;
		bit        typed;
		rsp_item_t want;
	} stim_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd_item  = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_item;

	// Behavioral copy of the stack, bottom entry at index 0
	logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
	int                       shadow_count = 0;

	rsp_item_t pending_rsp [$];
	stim_row_t stim_table [$];
	int        mismatch_cnt = 0;
	int        rsp_seen     = 0;
	int        hold_left    = 0;
	bit        hold_done    = 1'b0;
	bit        calm_run     = 1'b0;
	int        quiet_cycles = 0;

	stack_with_middle_ops i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	always #1 clk = ~clk;

	// Apply one command to the shadow stack and return its result
	function automatic rsp_item_t stack_apply(cmd_item_t it);
		rsp_item_t r;
		int        mid;
		r = '0;
		r.status = STATUS_OK;
		if (it.cmd == CMD_PUSH) begin
			if (shadow_count >= STACK_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				shadow_words[shadow_count] = it.push_value;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.status = STATUS_EMPTY;
		end else if (it.cmd == CMD_POP) begin
			r.data_out = shadow_words[shadow_count - 1];
			shadow_count--;
		end else begin
			mid = shadow_count / 2;
			r.data_out = shadow_words[mid];
			// close the gap left by the middle entry
			if (it.cmd == CMD_DEL_MD) begin
				for (int i = mid; i + 1 < shadow_count; i++)
					shadow_words[i] = shadow_words[i + 1];
				shadow_count--;
			end
		end
		r.depth_now = DEPTH_W'(shadow_count);
		return r;
	endfunction

	function automatic void add_row(logic [1:0] cmd, logic [DATA_W-1:0] value, bit typed,
			logic [DATA_W-1:0] data, logic [1:0] status, int depth);
		stim_row_t row;
		row.item.cmd        = cmd;
		row.item.push_value = value;
		row.typed           = typed;
		row.want.data_out   = data;
		row.want.status     = status;
		row.want.depth_now  = DEPTH_W'(depth);
		stim_table.push_back(row);
	endfunction

	// Offer one command, with random idle cycles ahead of it, and record the
	// expected result once the transfer happens
	task automatic send_cmd(cmd_item_t it, bit typed, rsp_item_t want);
		rsp_item_t pred;
		while (!calm_run && $urandom_range(99) < 8) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item  <= it;
		do @(posedge clk); while (cmd_stall);
		pred = stack_apply(it);
		pending_rsp.push_back(typed ? want : pred);
	endtask

	// Stimulus
	initial begin : stim
		int        seg_left;
		int        seg_no;
		int        push_w;
		cmd_item_t it;
		rsp_item_t none;
		seg_left = 0;
		seg_no   = 0;
		push_w   = 50;
		none     = '0;

		// Directed table: empty errors, extremes, single-entry delete, mixed ops
		add_row(CMD_POP,     32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY, 0);
		add_row(CMD_READ_MD, 32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY, 0);
		add_row(CMD_DEL_MD,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_EMPTY, 0);
		add_row(CMD_PUSH,    32'h7FFF_FFFF, 1'b1, 32'h0000_0000, STATUS_OK,    1);
		add_row(CMD_DEL_MD,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STATUS_OK,    0);
		add_row(CMD_POP,     32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY, 0);
		add_row(CMD_PUSH,    32'h8000_0000, 1'b1, 32'h0000_0000, STATUS_OK,    1);
		add_row(CMD_READ_MD, 32'h0000_0000, 1'b1, 32'h8000_0000, STATUS_OK,    1);
		add_row(CMD_PUSH,    32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_OK,    2);
		add_row(CMD_PUSH,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STATUS_OK,    3);
		add_row(CMD_PUSH,    32'h5555_5555, 1'b1, 32'h0000_0000, STATUS_OK,    4);
		add_row(CMD_PUSH,    32'hAAAA_AAAA, 1'b1, 32'h0000_0000, STATUS_OK,    5);
		add_row(CMD_READ_MD, 32'h0000_0000, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_DEL_MD,  32'h0000_0000, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_READ_MD, 32'h1234_5678, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_DEL_MD,  32'hDEAD_BEEF, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_POP,     32'h0000_0000, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_POP,     32'h7FFF_FFFF, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_DEL_MD,  32'h0000_0000, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_POP,     32'h0000_0000, 1'b1, 32'h0000_0000, STATUS_EMPTY, 0);
		add_row(CMD_PUSH,    32'h0000_0001, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_PUSH,    32'h0000_0002, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_PUSH,    32'h0000_0003, 1'b0, '0, STATUS_OK, 0);
		add_row(CMD_DEL_MD,  32'h0000_0000, 1'b0, '0, STATUS_OK, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_table[k])
			send_cmd(stim_table[k].item, stim_table[k].typed, stim_table[k].want);

		// Random bursts: each burst picks a push weight so the stack climbs to
		// full, hovers or drains; some bursts first wait for all pending results
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (seg_left == 0) begin
				seg_no++;
				seg_left = $urandom_range(160, 40);
				case ($urandom_range(4))
					0: begin
						push_w = 15;
					end
					1: begin
						push_w = 35;
					end
					2: begin
						push_w = 50;
					end
					3: begin
						push_w = 70;
					end
					default: begin
						push_w = 92;
					end
				endcase
				if (seg_no == 3 || $urandom_range(5) == 0) begin
					cmd_valid <= 1'b0;
					do @(posedge clk); while (pending_rsp.size() != 0);
				end
			end
			seg_left--;
			calm_run <= (n >= 700 && n < 900);
			it.push_value = $urandom;
			it.cmd = ($urandom_range(99) < push_w) ? CMD_PUSH :
				2'($urandom_range(CMD_DEL_MD, CMD_POP));
			send_cmd(it, 1'b0, none);
		end
		cmd_valid <= 1'b0;

		// Wait for the last results, then watch for stray ones
		do @(posedge clk); while (pending_rsp.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Score each result transfer and drive the output stall
	always @(posedge clk) begin : rsp_side
		rsp_item_t want;
		if (rsp_valid && !rsp_stall) begin
			rsp_seen++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result, data %0d status %0d depth %0d",
					$time, rsp_item.data_out, rsp_item.status, rsp_item.depth_now);
				mismatch_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_item.data_out !== want.data_out) begin
					$display("%0t: data_out expected %0d actual %0d",
						$time, want.data_out, rsp_item.data_out);
					mismatch_cnt++;
				end
				if (rsp_item.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp_item.status);
					mismatch_cnt++;
				end
				if (rsp_item.depth_now !== want.depth_now) begin
					$display("%0t: depth_now expected %0d actual %0d",
						$time, want.depth_now, rsp_item.depth_now);
					mismatch_cnt++;
				end
			end
		end

		// hold off once for a long stretch so the block backs up
		if (!hold_done && rsp_seen >= HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !calm_run && ($urandom_range(99) < 8);
		end
	end

	// Abort when no transfer happens on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIM) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
